>>> rtl/core/mtt_pkg.sv
// Package with shared types and constants for the timer table.
`timescale 1ns / 1ps
`default_nettype none
package mtt_pkg;
  localparam int TimerSlotsDefault = 32;
  localparam int MaxResults = 32;

  typedef enum logic [2:0] {
    FUNC_CREATE = 3'd0,
    FUNC_DELETE = 3'd1,
    FUNC_KILL   = 3'd2,
    FUNC_TICK   = 3'd3,
    FUNC_DELOWN = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    KIND_CREATED = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_NOTFND  = 3'd3,
    KIND_FIRED   = 3'd4,
    KIND_NOFIRE  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic        create;
    logic        del_id;
    logic        kill_id;
    logic        dec;
    logic        del_own;
    logic        retire;
    logic [31:0] id;
    logic [7:0]  owner;
    logic [15:0] handler;
    logic [31:0] interval;
    logic        repeating;
    logic [15:0] elapsed;
  } cmd_t;

  // Per-cell contents seen by the controller.
  typedef struct packed {
    logic        valid;
    logic        pend;
    logic [31:0] id;
    logic [7:0]  owner;
    logic [15:0] handler;
    logic        expired;
    logic        killed;
  } cell_stat_t;
endpackage
`default_nettype wire

>>> rtl/core/mtt_cell.sv
// One timer slot: holds the timer state and reports it to the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mtt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtt_pkg::cmd_t     cmd,
  input  wire logic              sel,
  input  wire logic              load_pend,
  output mtt_pkg::cell_stat_t    stat
);
  import mtt_pkg::*;

  logic        valid_r, valid_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] id_r, total_r, rem_r;
  logic [7:0]  owner_r;
  logic [15:0] handler_r;
  logic        repeat_r, killed_r;
  logic [32:0] diff;
  logic [31:0] dec_val;
  logic        expired;

  // A timer is due once its remaining time is zero or negative.
  assign expired = rem_r[31] || (rem_r == 32'd0);

  // Saturating subtract of the elapsed time.
  always_comb begin
    diff = {rem_r[31], rem_r} - {17'd0, cmd.elapsed};
    if (diff[32] != diff[31]) dec_val = 32'h8000_0000;
    else dec_val = diff[31:0];
  end

  // A retired timer leaves the pending set; only a due one-shot timer is removed.
  always_comb begin
    valid_nxt = valid_r;
    pend_nxt = pend_r;
    if (sel && cmd.create) valid_nxt = 1'b1;
    if (sel && (cmd.del_id || cmd.del_own)) valid_nxt = 1'b0;
    if (sel && cmd.retire) begin
      pend_nxt = 1'b0;
      if (expired && !repeat_r) valid_nxt = 1'b0;
    end
    if (load_pend) pend_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sel && cmd.create) begin
      id_r <= cmd.id;
      owner_r <= cmd.owner;
      handler_r <= cmd.handler;
      total_r <= cmd.interval;
      rem_r <= cmd.interval;
      repeat_r <= cmd.repeating;
      killed_r <= 1'b0;
    end else if (sel && cmd.kill_id) begin
      rem_r <= 32'd0;
      killed_r <= 1'b1;
      repeat_r <= 1'b0;
    end else if (cmd.dec && valid_r) begin
      rem_r <= dec_val;
    end else if (sel && cmd.retire && expired && repeat_r) begin
      rem_r <= total_r;
    end
  end

  always_comb begin
    stat.valid = valid_r;
    stat.pend = pend_r;
    stat.id = id_r;
    stat.owner = owner_r;
    stat.handler = handler_r;
    stat.expired = expired;
    stat.killed = killed_r;
  end
endmodule
`default_nettype wire

>>> rtl/core/mtt_ctrl.sv
// Sequencer that scans the cell row one slot per cycle and emits results.
`timescale 1ns / 1ps
`default_nettype none
module mtt_ctrl #(
  parameter int TimerSlots = mtt_pkg::TimerSlotsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_func,
  input  wire logic [31:0]                   in_interval,
  input  wire logic                          in_repeating,
  input  wire logic [7:0]                    in_owner,
  input  wire logic [15:0]                   in_handler,
  input  wire logic [31:0]                   in_timer_id,
  input  wire logic [15:0]                   in_elapsed,
  input  wire logic                          dispatch,
  input  wire mtt_pkg::cell_stat_t           stat [TimerSlots],
  output mtt_pkg::cmd_t                      cmd,
  output logic [TimerSlots-1:0]              sel,
  output logic                               load_pend,
  output logic                               out_strobe,
  output logic [2:0]                         out_kind,
  output logic [31:0]                        out_result_id,
  output logic [7:0]                         out_result_owner,
  output logic [15:0]                        out_result_handler,
  output logic [5:0]                         out_removed_count,
  output logic                               out_last
);
  import mtt_pkg::*;

  localparam int IW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;

  state_t      state_r, state_nxt;
  logic [2:0]  func_r;
  logic [31:0] interval_r, tid_r, ctr_r, best_id_r;
  logic        rep_r;
  logic [7:0]  owner_r;
  logic [15:0] handler_r, elapsed_r;
  logic [IW-1:0] idx_r, best_r;
  logic        found_r, fired;
  logic [5:0]  cnt_r, nres_r;
  logic        scan_end;
  cell_stat_t  cur;
  logic        hit;

  assign cur = stat[idx_r];
  assign scan_end = (idx_r == IW'(TimerSlots - 1));
  assign busy = (state_r != ST_IDLE);

  // Per-slot match during a scan.
  always_comb begin
    hit = 1'b0;
    case (func_t'(func_r))
      FUNC_CREATE: hit = !cur.valid;
      FUNC_DELETE, FUNC_KILL: hit = cur.valid && cur.id == tid_r;
      FUNC_DELOWN: hit = cur.valid && cur.owner == owner_r;
      FUNC_TICK: hit = cur.pend && (!found_r || cur.id < best_id_r);
      default: hit = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) begin
        if (in_func <= FUNC_DELOWN) state_nxt = ST_SCAN;
      end
      ST_SCAN: if (scan_end ||
                   (hit && func_r != FUNC_DELOWN && func_r != FUNC_TICK))
                 state_nxt = (func_r == FUNC_TICK) ? ST_PICK : ST_DONE;
      ST_PICK: state_nxt = found_r ? ST_SCAN : ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Registers of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCAN && func_r == FUNC_CREATE && hit) ctr_r <= ctr_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        func_r <= in_func; interval_r <= in_interval; rep_r <= in_repeating;
        owner_r <= in_owner; handler_r <= in_handler; tid_r <= in_timer_id;
        elapsed_r <= in_elapsed;
        idx_r <= '0; found_r <= 1'b0; cnt_r <= '0; nres_r <= '0;
      end
      ST_SCAN: begin
        if (hit) begin
          found_r <= 1'b1;
          best_r <= idx_r;
          best_id_r <= cur.id;
          if (func_r == FUNC_DELOWN && cnt_r != 6'd63) cnt_r <= cnt_r + 6'd1;
        end
        if (!scan_end) idx_r <= idx_r + IW'(1);
      end
      ST_PICK: begin
        idx_r <= '0;
        found_r <= 1'b0;
        if (fired) nres_r <= nres_r + 6'd1;
      end
      default: ;
    endcase
  end

  assign fired = found_r && stat[best_r].expired && !stat[best_r].killed &&
                 dispatch && stat[best_r].owner != 8'd0 &&
                 nres_r < 6'(MaxResults);

  // Commands to the cells.
  always_comb begin
    cmd = '0;
    sel = '0;
    load_pend = 1'b0;
    cmd.id = ctr_r + 32'd1;
    cmd.owner = owner_r;
    cmd.handler = handler_r;
    cmd.interval = interval_r;
    cmd.repeating = rep_r;
    cmd.elapsed = elapsed_r;
    if (state_r == ST_SCAN && hit && func_r != FUNC_TICK) begin
      sel[idx_r] = 1'b1;
      cmd.create = (func_r == FUNC_CREATE);
      cmd.del_id = (func_r == FUNC_DELETE);
      cmd.kill_id = (func_r == FUNC_KILL);
      cmd.del_own = (func_r == FUNC_DELOWN);
    end
    // A tick first decrements all slots and marks the valid ones pending.
    if (state_r == ST_IDLE && start && in_func == FUNC_TICK) begin
      cmd.dec = 1'b1;
      cmd.elapsed = in_elapsed;
      load_pend = 1'b1;
    end
    // The picked timer leaves the pending set; the cell reloads or removes it if due.
    if (state_r == ST_PICK && found_r) begin
      sel[best_r] = 1'b1;
      cmd.retire = 1'b1;
    end
  end

  // Results.
  always_comb begin
    out_strobe = 1'b0;
    out_kind = KIND_DONE;
    out_result_id = 32'd0;
    out_result_owner = 8'd0;
    out_result_handler = 16'd0;
    out_removed_count = 6'd0;
    out_last = 1'b0;
    if (state_r == ST_PICK && fired) begin
      out_strobe = 1'b1;
      out_kind = KIND_FIRED;
      out_result_id = best_id_r;
      out_result_owner = stat[best_r].owner;
      out_result_handler = stat[best_r].handler;
    end
    if (state_r == ST_DONE) begin
      out_strobe = 1'b1;
      out_last = 1'b1;
      case (func_t'(func_r))
        FUNC_CREATE: begin
          out_kind = found_r ? KIND_CREATED : KIND_FULL;
          out_result_id = found_r ? ctr_r : 32'd0;
        end
        FUNC_DELETE, FUNC_KILL: out_kind = found_r ? KIND_DONE : KIND_NOTFND;
        FUNC_DELOWN: out_removed_count = cnt_r;
        // The top level swaps this for a held fire when the tick reported any.
        FUNC_TICK: out_kind = KIND_NOFIRE;
        default: out_strobe = 1'b0;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/multi_timer_table.sv
// Top level of the timer table: cell row, sequencer and configuration.
// Usage: raise start with the operation fields while busy is low; the command
// is accepted at that edge. Results appear on the out_ ports for one cycle
// each, marked by out_strobe; out_last marks the final result of a command.
// The receiver cannot stall the block, so results never wait.
// Create, delete, kill and delete-for-owner scan the slots one per cycle and
// give their single result when the scan ends;
// the next command is taken in the cycle after that result.
// A tick decrements every slot at once, then runs passes (scan plus pick),
// one per timer that was live, plus a final empty pass; busy stays high throughout.
// Each fire is held back until the next fire or the end of the tick, so the
// last fire, or a lone kind 5 result, comes out in the final cycle with last.
// Unknown operation codes are accepted and dropped without a result.
// The configuration channel (cfg_valid/cfg_ready) sets dispatch_enable; it is
// always ready, and the block is meant to be idle during a write.
// Reset clears all slots, the id counter and sets dispatch_enable to 1.
`timescale 1ns / 1ps
`default_nettype none
module multi_timer_table #(
  parameter int TIMER_SLOTS = mtt_pkg::TimerSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic signed [31:0] in_interval,
  input  wire logic        in_repeating,
  input  wire logic [7:0]  in_owner,
  input  wire logic [15:0] in_handler,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [15:0] in_elapsed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_dispatch_enable,
  output logic             out_strobe,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_result_id,
  output logic [7:0]       out_result_owner,
  output logic [15:0]      out_result_handler,
  output logic [5:0]       out_removed_count,
  output logic             out_last
);
  import mtt_pkg::*;

  logic dispatch_r;
  cmd_t cmd;
  cell_stat_t stat [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] sel;
  logic load_pend;
  logic [2:0] kind_c;
  logic strobe_c, last_c;
  logic [31:0] id_c;
  logic [7:0] own_c;
  logic [15:0] hnd_c;
  logic [5:0] cnt_c;
  logic        hold_v_r;
  logic [31:0] hold_id_r;
  logic [7:0]  hold_own_r;
  logic [15:0] hold_hnd_r;
  logic        fire_c;
  logic        end_c;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) dispatch_r <= 1'b1;
    else if (cfg_valid && cfg_ready) dispatch_r <= cfg_dispatch_enable;
  end

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    mtt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel(sel[g]),
      .load_pend(load_pend), .stat(stat[g])
    );
  end

  mtt_ctrl #(.TimerSlots(TIMER_SLOTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_interval(in_interval), .in_repeating(in_repeating),
    .in_owner(in_owner), .in_handler(in_handler), .in_timer_id(in_timer_id),
    .in_elapsed(in_elapsed), .dispatch(dispatch_r), .stat(stat), .cmd(cmd),
    .sel(sel), .load_pend(load_pend), .out_strobe(strobe_c), .out_kind(kind_c),
    .out_result_id(id_c), .out_result_owner(own_c), .out_result_handler(hnd_c),
    .out_removed_count(cnt_c), .out_last(last_c)
  );

  // A fire from the sequencer, and the closing result of a tick.
  assign fire_c = strobe_c && kind_c == KIND_FIRED;
  assign end_c = strobe_c && kind_c == KIND_NOFIRE;

  // Fires are held back so the final one can carry the last flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      if (fire_c) hold_v_r <= 1'b1;
      else if (end_c) hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_c) begin
      hold_id_r <= id_c; hold_own_r <= own_c; hold_hnd_r <= hnd_c;
    end
  end

  // Output mux.
  always_comb begin
    out_strobe = strobe_c && !fire_c;
    out_kind = kind_c;
    out_result_id = id_c;
    out_result_owner = own_c;
    out_result_handler = hnd_c;
    out_removed_count = cnt_c;
    out_last = last_c;
    if (fire_c && hold_v_r) begin
      out_strobe = 1'b1; out_kind = KIND_FIRED; out_last = 1'b0;
      out_result_id = hold_id_r; out_result_owner = hold_own_r;
      out_result_handler = hold_hnd_r; out_removed_count = 6'd0;
    end
    if (end_c && hold_v_r) begin
      out_kind = KIND_FIRED; out_result_id = hold_id_r;
      out_result_owner = hold_own_r; out_result_handler = hold_hnd_r;
    end
  end
endmodule
`default_nettype wire
